@@ rtl/core/tci_pkg.sv @@
// Shared widths, pipeline depths and side-band structs for the
// two-circle intersection core. No dependencies.
package tci_pkg;

  localparam int POS_W     = 24;  // landmark and result coordinates, Q8
  localparam int DIST_W    = 23;  // distances, Q8
  localparam int DIFF_W    = 25;  // landmark difference, Q8
  localparam int SQR_W     = 50;  // squared difference terms, Q16
  localparam int DSQ_W     = 46;  // squared distances, Q16
  localparam int NUM_W     = 52;  // law-of-cosines numerator, signed
  localparam int DEN_W     = 49;  // 2*d*first_dist
  localparam int SQ_W      = 62;  // radicand width of the root unit
  localparam int ROOT_W    = 31;  // root width, one root bit per stage
  localparam int DV_W      = 50;  // dividend and divisor width of the divider
  localparam int QU_W      = 31;  // quotient width, one quotient bit per stage
  localparam int Q_W       = 32;  // signed Q30 unit values
  localparam int RV_W      = 34;  // rotated unit vector after rounding
  localparam int OFS_W     = 58;  // rotated vector times first_dist
  localparam int SUM_W     = 29;  // landmark plus offset before saturation
  localparam int LATENCY   = 105; // start to done, length of the valid pipe

  localparam logic signed [Q_W-1:0]  ONE_Q30 = Q_W'(1) <<< 30;
  localparam logic [QU_W-1:0]        ONE_MAG = QU_W'(1) << 30;
  localparam logic [SQ_W-1:0]        ONE_Q60 = SQ_W'(1) << 60;
  localparam logic signed [63:0]     HALF64  = 64'sd1 <<< 29;
  localparam logic signed [OFS_W-1:0] HALF58 = OFS_W'(1) <<< 29;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  // fields that ride the whole pipe
  typedef struct packed {
    logic                     ddz;  // landmarks coincide
    logic                     z1;   // first distance is zero
    logic                     z2;   // second distance is zero
    logic signed [POS_W-1:0]  x1;
    logic signed [POS_W-1:0]  y1;
    logic signed [POS_W-1:0]  x2;
    logic signed [POS_W-1:0]  y2;
    logic [DIST_W-1:0]        d1;
  } base_t;

  // alongside the first root
  typedef struct packed {
    logic signed [NUM_W-1:0]  num;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } segb_t;

  // alongside the dividers
  typedef struct packed {
    logic cpos;
    logic cneg;
    logic nneg;
    logic dxn;
    logic dyn;
  } segc_t;

  // alongside the second root
  typedef struct packed {
    logic signed [Q_W-1:0] c;
    logic signed [Q_W-1:0] ux;
    logic signed [Q_W-1:0] uy;
  } segd_t;

endpackage

@@ rtl/core/tci_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Depends on tci_pkg for widths.
module tci_isqrt (
  input  logic                        clk_i,
  input  logic [tci_pkg::SQ_W-1:0]    rad_i,
  output logic [tci_pkg::ROOT_W-1:0]  root_o
);

  logic [tci_pkg::SQ_W-1:0] n_q [tci_pkg::ROOT_W-1];
  logic [tci_pkg::SQ_W-1:0] r_q [tci_pkg::ROOT_W];

  for (genvar i = 0; i < tci_pkg::ROOT_W; i++) begin : g_stage
    localparam logic [tci_pkg::SQ_W-1:0] BIT =
      tci_pkg::SQ_W'(1) << (tci_pkg::SQ_W - 2 - 2 * i);
    logic [tci_pkg::SQ_W-1:0] n_in, r_in, t, n_d, r_d;

    if (i == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
    end

    always_comb begin
      t = r_in + BIT;
      if (n_in >= t) begin
        n_d = n_in - t;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[i] <= r_d;
    end

    if (i < tci_pkg::ROOT_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        n_q[i] <= n_d;
      end
    end else begin : g_drop
      logic unused_n;
      assign unused_n = ^n_d;
    end
  end

  assign root_o = r_q[tci_pkg::ROOT_W-1][tci_pkg::ROOT_W-1:0];

endmodule

@@ rtl/core/tci_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Gives floor(num * 2^30 / den) for num < 2*den. Depends on tci_pkg.
module tci_div (
  input  logic                      clk_i,
  input  logic [tci_pkg::DV_W-1:0]  num_i,
  input  logic [tci_pkg::DV_W-1:0]  den_i,
  output logic [tci_pkg::QU_W-1:0]  quo_o
);

  logic [tci_pkg::DV_W:0]   rem_q [tci_pkg::QU_W-1];
  logic [tci_pkg::DV_W-1:0] den_q [tci_pkg::QU_W-1];
  logic [tci_pkg::QU_W-1:0] quo_q [tci_pkg::QU_W];

  for (genvar i = 0; i < tci_pkg::QU_W; i++) begin : g_stage
    logic [tci_pkg::DV_W:0]   r_in, r_d;
    logic [tci_pkg::DV_W-1:0] d_in;
    logic [tci_pkg::QU_W-1:0] q_in;
    logic                     ge;

    if (i == 0) begin : g_first
      assign r_in = {1'b0, num_i};
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      // bring in the next zero bit of the shifted dividend
      assign r_in = {rem_q[i-1][tci_pkg::DV_W-1:0], 1'b0};
      assign d_in = den_q[i-1];
      assign q_in = quo_q[i-1];
    end

    always_comb begin
      ge  = r_in >= {1'b0, d_in};
      r_d = ge ? r_in - {1'b0, d_in} : r_in;
    end

    always_ff @(posedge clk_i) begin
      quo_q[i] <= {q_in[tci_pkg::QU_W-2:0], ge};
    end

    if (i < tci_pkg::QU_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rem_q[i] <= r_d;
        den_q[i] <= d_in;
      end
    end else begin : g_drop
      logic unused_r;
      assign unused_r = ^r_d;
    end
  end

  assign quo_o = quo_q[tci_pkg::QU_W-1];

endmodule

@@ rtl/core/two_circle_intersection_core.sv @@
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// request   | start / busy       | first_x/y_i, first_dist_i, second_x/y_i, second_dist_i
// result    | done_o (one cycle) | valid_res_o, pos_a_x/y_o, pos_b_x/y_o
//
// Fully pipelined: one item per cycle.
// The depth is set by the two 31-stage root units and the 31-stage dividers.
// busy stays low; the result side cannot stall, so nothing is ever held.
// Reset clears only the valid pipe; data stages carry no reset.
// Depends on tci_pkg, tci_isqrt and tci_div.
module two_circle_intersection_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tci_pkg::POS_W-1:0]     first_x_i,
  input  logic signed [tci_pkg::POS_W-1:0]     first_y_i,
  input  logic [tci_pkg::DIST_W-1:0]           first_dist_i,
  input  logic signed [tci_pkg::POS_W-1:0]     second_x_i,
  input  logic signed [tci_pkg::POS_W-1:0]     second_y_i,
  input  logic [tci_pkg::DIST_W-1:0]           second_dist_i,
  output logic                                 done_o,
  output logic                                 valid_res_o,
  output logic signed [tci_pkg::POS_W-1:0]     pos_a_x_o,
  output logic signed [tci_pkg::POS_W-1:0]     pos_a_y_o,
  output logic signed [tci_pkg::POS_W-1:0]     pos_b_x_o,
  output logic signed [tci_pkg::POS_W-1:0]     pos_b_y_o
);

  function automatic logic signed [tci_pkg::POS_W-1:0] sat_pos(
    input logic signed [tci_pkg::SUM_W-1:0] v
  );
    logic signed [tci_pkg::POS_W-1:0] r;
    if (v > tci_pkg::SUM_W'(tci_pkg::POS_MAX)) begin
      r = tci_pkg::POS_MAX;
    end else if (v < tci_pkg::SUM_W'(tci_pkg::POS_MIN)) begin
      r = tci_pkg::POS_MIN;
    end else begin
      r = v[tci_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  logic accept;
  logic [tci_pkg::LATENCY-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[tci_pkg::LATENCY-2:0], accept};
    end
  end

  assign done_o = vld_q[tci_pkg::LATENCY-1];

  // ---- stage 1: differences and special-case flags
  tci_pkg::base_t                    b1_q, b2_q, b3_q;
  logic signed [tci_pkg::DIFF_W-1:0] dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  logic [tci_pkg::DIST_W-1:0]        d2_1_q;

  always_ff @(posedge clk_i) begin
    b1_q.ddz <= (first_x_i == second_x_i) && (first_y_i == second_y_i);
    b1_q.z1  <= first_dist_i == '0;
    b1_q.z2  <= second_dist_i == '0;
    b1_q.x1  <= first_x_i;
    b1_q.y1  <= first_y_i;
    b1_q.x2  <= second_x_i;
    b1_q.y2  <= second_y_i;
    b1_q.d1  <= first_dist_i;
    d2_1_q   <= second_dist_i;
    dx1_q    <= tci_pkg::DIFF_W'(second_x_i) - tci_pkg::DIFF_W'(first_x_i);
    dy1_q    <= tci_pkg::DIFF_W'(second_y_i) - tci_pkg::DIFF_W'(first_y_i);
  end

  // ---- stage 2: squares
  logic [tci_pkg::SQR_W-1:0] dxx2_q, dyy2_q;
  logic [tci_pkg::DSQ_W-1:0] d1s2_q, d2s2_q;

  always_ff @(posedge clk_i) begin
    dxx2_q <= tci_pkg::SQR_W'(dx1_q * dx1_q);
    dyy2_q <= tci_pkg::SQR_W'(dy1_q * dy1_q);
    d1s2_q <= tci_pkg::DSQ_W'(b1_q.d1 * b1_q.d1);
    d2s2_q <= tci_pkg::DSQ_W'(d2_1_q * d2_1_q);
    b2_q   <= b1_q;
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
  end

  // ---- stage 3: squared spacing and cosine numerator
  logic [tci_pkg::SQR_W-1:0]         dd3_q;
  logic signed [tci_pkg::NUM_W-1:0]  num3_q;

  always_ff @(posedge clk_i) begin
    dd3_q  <= dxx2_q + dyy2_q;
    num3_q <= $signed(tci_pkg::NUM_W'(d1s2_q) + tci_pkg::NUM_W'(dxx2_q)
                      + tci_pkg::NUM_W'(dyy2_q) - tci_pkg::NUM_W'(d2s2_q));
    b3_q   <= b2_q;
    dx3_q  <= dx2_q;
    dy3_q  <= dy2_q;
  end

  // ---- spacing root
  logic [tci_pkg::ROOT_W-1:0] root1;
  tci_pkg::base_t bb_q [tci_pkg::ROOT_W];
  tci_pkg::segb_t xb_q [tci_pkg::ROOT_W];

  tci_isqrt u_root_dist (
    .clk_i  (clk_i),
    .rad_i  (tci_pkg::SQ_W'(dd3_q)),
    .root_o (root1)
  );

  always_ff @(posedge clk_i) begin
    bb_q[0]     <= b3_q;
    xb_q[0].num <= num3_q;
    xb_q[0].dx  <= dx3_q;
    xb_q[0].dy  <= dy3_q;
    for (int i = 1; i < tci_pkg::ROOT_W; i++) begin
      bb_q[i] <= bb_q[i-1];
      xb_q[i] <= xb_q[i-1];
    end
  end

  // ---- C1: denominator
  tci_pkg::base_t                    bc1_q;
  tci_pkg::segb_t                    xc1_q;
  logic [tci_pkg::DIFF_W-1:0]        dc1_q;
  logic [tci_pkg::DEN_W-1:0]         den_c1_q;
  logic [tci_pkg::DIFF_W-1:0]        dist_d;
  tci_pkg::base_t                    bb_end;

  assign bb_end = bb_q[tci_pkg::ROOT_W-1];
  assign dist_d = root1[tci_pkg::DIFF_W-1:0];

  always_ff @(posedge clk_i) begin
    den_c1_q <= {(tci_pkg::DEN_W-1)'(dist_d * bb_end.d1), 1'b0};
    dc1_q    <= dist_d;
    bc1_q    <= bb_end;
    xc1_q    <= xb_q[tci_pkg::ROOT_W-1];
  end

  // ---- C2: clamp decision, magnitudes for the dividers
  logic signed [tci_pkg::NUM_W-1:0] den_s;
  logic [tci_pkg::NUM_W-1:0]        num_mag;
  logic [tci_pkg::DIFF_W-1:0]       dx_mag, dy_mag;
  logic [tci_pkg::DV_W-1:0]         nm_c2_q, den_c2_q, dxm_c2_q, dym_c2_q, d_c2_q;
  tci_pkg::base_t                   bc2_q;
  tci_pkg::segc_t                   xc2_q;

  always_comb begin
    den_s   = $signed(tci_pkg::NUM_W'(den_c1_q));
    num_mag = xc1_q.num[tci_pkg::NUM_W-1] ? tci_pkg::NUM_W'(-xc1_q.num)
                                           : tci_pkg::NUM_W'(xc1_q.num);
    dx_mag  = xc1_q.dx[tci_pkg::DIFF_W-1] ? tci_pkg::DIFF_W'(-xc1_q.dx)
                                           : tci_pkg::DIFF_W'(xc1_q.dx);
    dy_mag  = xc1_q.dy[tci_pkg::DIFF_W-1] ? tci_pkg::DIFF_W'(-xc1_q.dy)
                                           : tci_pkg::DIFF_W'(xc1_q.dy);
  end

  always_ff @(posedge clk_i) begin
    xc2_q.cpos <= xc1_q.num >= den_s;
    xc2_q.cneg <= xc1_q.num <= -den_s;
    xc2_q.nneg <= xc1_q.num[tci_pkg::NUM_W-1];
    xc2_q.dxn  <= xc1_q.dx[tci_pkg::DIFF_W-1];
    xc2_q.dyn  <= xc1_q.dy[tci_pkg::DIFF_W-1];
    // a clamped numerator may not fit; its quotient is dropped anyway
    nm_c2_q    <= num_mag[tci_pkg::DV_W-1:0];
    den_c2_q   <= tci_pkg::DV_W'(den_c1_q);
    dxm_c2_q   <= tci_pkg::DV_W'(dx_mag);
    dym_c2_q   <= tci_pkg::DV_W'(dy_mag);
    d_c2_q     <= tci_pkg::DV_W'(dc1_q);
    bc2_q      <= bc1_q;
  end

  // ---- dividers: cosine and unit vector
  logic [tci_pkg::QU_W-1:0] qc, qx, qy;
  tci_pkg::base_t bcd_q [tci_pkg::QU_W];
  tci_pkg::segc_t xcd_q [tci_pkg::QU_W];

  tci_div u_div_cos (.clk_i(clk_i), .num_i(nm_c2_q),  .den_i(den_c2_q), .quo_o(qc));
  tci_div u_div_ux  (.clk_i(clk_i), .num_i(dxm_c2_q), .den_i(d_c2_q),   .quo_o(qx));
  tci_div u_div_uy  (.clk_i(clk_i), .num_i(dym_c2_q), .den_i(d_c2_q),   .quo_o(qy));

  always_ff @(posedge clk_i) begin
    bcd_q[0] <= bc2_q;
    xcd_q[0] <= xc2_q;
    for (int i = 1; i < tci_pkg::QU_W; i++) begin
      bcd_q[i] <= bcd_q[i-1];
      xcd_q[i] <= xcd_q[i-1];
    end
  end

  // ---- E: signs and clamp
  tci_pkg::segc_t           xc_end;
  tci_pkg::segd_t           xe_q, xf_q;
  tci_pkg::base_t           be_q, bf_q, bg_q;
  logic [tci_pkg::QU_W-1:0] cm_e_q;
  logic signed [tci_pkg::Q_W-1:0] qc_s, qx_s, qy_s;

  assign xc_end = xcd_q[tci_pkg::QU_W-1];
  assign qc_s   = $signed(tci_pkg::Q_W'(qc));
  assign qx_s   = $signed(tci_pkg::Q_W'(qx));
  assign qy_s   = $signed(tci_pkg::Q_W'(qy));

  always_ff @(posedge clk_i) begin
    if (xc_end.cpos) begin
      xe_q.c <= tci_pkg::ONE_Q30;
      cm_e_q <= tci_pkg::ONE_MAG;
    end else if (xc_end.cneg) begin
      xe_q.c <= -tci_pkg::ONE_Q30;
      cm_e_q <= tci_pkg::ONE_MAG;
    end else begin
      xe_q.c <= xc_end.nneg ? -qc_s : qc_s;
      cm_e_q <= qc;
    end
    xe_q.ux <= xc_end.dxn ? -qx_s : qx_s;
    xe_q.uy <= xc_end.dyn ? -qy_s : qy_s;
    be_q    <= bcd_q[tci_pkg::QU_W-1];
  end

  // ---- F: cosine squared; G: radicand of the sine
  logic [tci_pkg::SQ_W-1:0] cc_f_q, rad_g_q;
  tci_pkg::segd_t           xg_q;

  always_ff @(posedge clk_i) begin
    cc_f_q  <= tci_pkg::SQ_W'(cm_e_q * cm_e_q);
    xf_q    <= xe_q;
    bf_q    <= be_q;
    rad_g_q <= tci_pkg::ONE_Q60 - cc_f_q;
    xg_q    <= xf_q;
    bg_q    <= bf_q;
  end

  // ---- sine root
  logic [tci_pkg::ROOT_W-1:0] sine;
  tci_pkg::base_t bd_q [tci_pkg::ROOT_W];
  tci_pkg::segd_t xd_q [tci_pkg::ROOT_W];

  tci_isqrt u_root_sin (
    .clk_i  (clk_i),
    .rad_i  (rad_g_q),
    .root_o (sine)
  );

  always_ff @(posedge clk_i) begin
    bd_q[0] <= bg_q;
    xd_q[0] <= xg_q;
    for (int i = 1; i < tci_pkg::ROOT_W; i++) begin
      bd_q[i] <= bd_q[i-1];
      xd_q[i] <= xd_q[i-1];
    end
  end

  // ---- H: rotation products
  logic signed [tci_pkg::Q_W-1:0] hc, hux, huy, hs;
  logic signed [63:0]             puc_q, pus_q, pvs_q, pvc_q;
  tci_pkg::base_t                 bh_q, bi_q, bj_q;

  always_comb begin
    hc  = xd_q[tci_pkg::ROOT_W-1].c;
    hux = xd_q[tci_pkg::ROOT_W-1].ux;
    huy = xd_q[tci_pkg::ROOT_W-1].uy;
    hs  = $signed(tci_pkg::Q_W'(sine));
  end

  always_ff @(posedge clk_i) begin
    puc_q <= 64'(hux * hc);
    pus_q <= 64'(hux * hs);
    pvs_q <= 64'(huy * hs);
    pvc_q <= 64'(huy * hc);
    bh_q  <= bd_q[tci_pkg::ROOT_W-1];
  end

  // ---- I: rotated unit vectors, round half up to Q30
  logic signed [63:0] sax, say, sbx, sby;
  logic signed [tci_pkg::RV_W-1:0] ax_i_q, ay_i_q, bx_i_q, by_i_q;

  always_comb begin
    sax = puc_q + pvs_q + tci_pkg::HALF64;
    say = pvc_q - pus_q + tci_pkg::HALF64;
    sbx = puc_q - pvs_q + tci_pkg::HALF64;
    sby = pus_q + pvc_q + tci_pkg::HALF64;
  end

  always_ff @(posedge clk_i) begin
    ax_i_q <= sax[63:30];
    ay_i_q <= say[63:30];
    bx_i_q <= sbx[63:30];
    by_i_q <= sby[63:30];
    bi_q   <= bh_q;
  end

  // ---- J: scale by the first distance
  logic signed [tci_pkg::DIST_W:0]  d1_s;
  logic signed [tci_pkg::OFS_W-1:0] max_j_q, may_j_q, mbx_j_q, mby_j_q;

  assign d1_s = $signed({1'b0, bi_q.d1});

  always_ff @(posedge clk_i) begin
    max_j_q <= tci_pkg::OFS_W'(ax_i_q * d1_s);
    may_j_q <= tci_pkg::OFS_W'(ay_i_q * d1_s);
    mbx_j_q <= tci_pkg::OFS_W'(bx_i_q * d1_s);
    mby_j_q <= tci_pkg::OFS_W'(by_i_q * d1_s);
    bj_q    <= bi_q;
  end

  // ---- K: round to Q8, add landmark, saturate, pick special cases
  logic signed [tci_pkg::OFS_W-1:0] rax, ray, rbx, rby;
  logic signed [tci_pkg::SUM_W-1:0] pax, pay, pbx, pby;
  logic                             vres_q;
  logic signed [tci_pkg::POS_W-1:0] pax_q, pay_q, pbx_q, pby_q;

  always_comb begin
    rax = max_j_q + tci_pkg::HALF58;
    ray = may_j_q + tci_pkg::HALF58;
    rbx = mbx_j_q + tci_pkg::HALF58;
    rby = mby_j_q + tci_pkg::HALF58;
    pax = tci_pkg::SUM_W'(bj_q.x1)
          + tci_pkg::SUM_W'($signed(rax[tci_pkg::OFS_W-1:30]));
    pay = tci_pkg::SUM_W'(bj_q.y1)
          + tci_pkg::SUM_W'($signed(ray[tci_pkg::OFS_W-1:30]));
    pbx = tci_pkg::SUM_W'(bj_q.x1)
          + tci_pkg::SUM_W'($signed(rbx[tci_pkg::OFS_W-1:30]));
    pby = tci_pkg::SUM_W'(bj_q.y1)
          + tci_pkg::SUM_W'($signed(rby[tci_pkg::OFS_W-1:30]));
  end

  always_ff @(posedge clk_i) begin
    if (bj_q.ddz) begin
      vres_q <= 1'b0;
      pax_q  <= '0;
      pay_q  <= '0;
      pbx_q  <= '0;
      pby_q  <= '0;
    end else if (bj_q.z1) begin
      vres_q <= 1'b1;
      pax_q  <= bj_q.x1;
      pay_q  <= bj_q.y1;
      pbx_q  <= bj_q.x1;
      pby_q  <= bj_q.y1;
    end else if (bj_q.z2) begin
      vres_q <= 1'b1;
      pax_q  <= bj_q.x2;
      pay_q  <= bj_q.y2;
      pbx_q  <= bj_q.x2;
      pby_q  <= bj_q.y2;
    end else begin
      vres_q <= 1'b1;
      pax_q  <= sat_pos(pax);
      pay_q  <= sat_pos(pay);
      pbx_q  <= sat_pos(pbx);
      pby_q  <= sat_pos(pby);
    end
  end

  assign valid_res_o = vres_q;
  assign pos_a_x_o   = pax_q;
  assign pos_a_y_o   = pay_q;
  assign pos_b_x_o   = pbx_q;
  assign pos_b_y_o   = pby_q;

  // every accepted item comes out after the fixed pipe depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(tci_pkg::LATENCY) done_o)
    else $error("item did not leave the pipe on time");

  // an unsolved result carries zero positions
  a_unsolved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (pos_a_x_o == '0 && pos_a_y_o == '0
                                  && pos_b_x_o == '0 && pos_b_y_o == '0))
    else $error("unsolved result with nonzero position");

endmodule
